// File: design/yuyv_rgb_pkg.sv
package yuyv_rgb_pkg;

  // Fixed point: 16 fractional bits, coefficients rounded to nearest
  localparam int FRAC_BITS = 16;
  localparam int SUM_W     = 26;

  localparam logic signed [17:0] COEF_RV = 18'sd89831;
  localparam logic signed [17:0] COEF_GV = 18'sd45744;
  localparam logic signed [17:0] COEF_GU = 18'sd22127;
  localparam logic signed [17:0] COEF_BU = 18'sd113538;

  localparam logic signed [8:0] CHROMA_OFFSET = 9'sd128;
  localparam logic [7:0]        CHANNEL_MAX   = 8'd255;
  localparam logic [7:0]        DIM_NUM       = 8'd220;

  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic [7:0] first_luma;
    logic [7:0] blue_chroma;
    logic [7:0] second_luma;
    logic [7:0] red_chroma;
    logic       frame_end;
  } pixel_word_t;

  typedef struct packed {
    logic [7:0] first_red;
    logic [7:0] first_green;
    logic [7:0] first_blue;
    logic [7:0] second_red;
    logic [7:0] second_green;
    logic [7:0] second_blue;
    logic       frame_end_out;
  } result_t;

  // Chroma products shared by both pixels of a word
  typedef struct packed {
    sum_t rv;
    sum_t gv;
    sum_t gu;
    sum_t bu;
  } chroma_prod_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Floor, clamp to 0..255, dim by 220/256
  function automatic logic [7:0] clamp_dim(input sum_t sum);
    logic [8:0]  whole;
    logic [7:0]  chan;
    logic [15:0] dimmed;
    whole = sum[SUM_W-2:FRAC_BITS];
    if (sum[SUM_W-1]) begin
      chan = 8'd0;
    end else if (whole[8]) begin
      chan = CHANNEL_MAX;
    end else begin
      chan = whole[7:0];
    end
    dimmed = {8'd0, chan} * {8'd0, DIM_NUM};
    return dimmed[15:8];
  endfunction

endpackage

// File: design/yuyv_to_rgb24_converter.sv
// YUYV 4:2:2 to RGB888 converter, two pixels per transaction.
// done is the valid bit of the clamp/dim stage and rises together with the result it marks.
// Throughput: one transaction per cycle; busy stays low, the pipeline never stalls.
// Reset (rst, synchronous) clears the valid bits only; data registers run freely.
// Results are shown for exactly one cycle; the receiver cannot stall.
module yuyv_to_rgb24_converter
  import yuyv_rgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  pixel_word_t pixel_word,
  output logic        done,
  output result_t     result
);

  // Valid bits for the three stages: products, sums, clamp/dim
  logic valid_prod;
  logic valid_sum;
  logic valid_out;

  // Luma and end-of-frame mark travel alongside the products
  logic [7:0]   luma_a;
  logic [7:0]   luma_b;
  logic         frame_end_prod;
  logic         frame_end_sum;
  logic         frame_end_out;
  chroma_prod_t prod;

  logic signed [8:0]  cu;
  logic signed [8:0]  cv;
  logic signed [26:0] full_rv;
  logic signed [26:0] full_gv;
  logic signed [26:0] full_gu;
  logic signed [26:0] full_bu;

  rgb_t rgb_a;
  rgb_t rgb_b;

  // Nothing here ever holds the input off
  assign busy = 1'b0;

  // Remove the chroma offset; both results fit in nine signed bits
  assign cu = $signed({1'b0, pixel_word.blue_chroma}) - CHROMA_OFFSET;
  assign cv = $signed({1'b0, pixel_word.red_chroma}) - CHROMA_OFFSET;

  assign full_rv = cv * COEF_RV;
  assign full_gv = cv * COEF_GV;
  assign full_gu = cu * COEF_GU;
  assign full_bu = cu * COEF_BU;

  // Valid pipeline: each bit moves on to the next stage, drop on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_prod <= 1'b0;
      valid_sum  <= 1'b0;
      valid_out  <= 1'b0;
    end else begin
      valid_prod <= start & ~busy;
      valid_sum  <= valid_prod;
      valid_out  <= valid_sum;
    end
  end

  // Product stage: register the four chroma products; these registers run freely, valid or not
  always_ff @(posedge clk) begin
    prod.rv        <= full_rv[SUM_W-1:0];
    prod.gv        <= full_gv[SUM_W-1:0];
    prod.gu        <= full_gu[SUM_W-1:0];
    prod.bu        <= full_bu[SUM_W-1:0];
    luma_a         <= pixel_word.first_luma;
    luma_b         <= pixel_word.second_luma;
    frame_end_prod <= pixel_word.frame_end;
    frame_end_sum  <= frame_end_prod;
    frame_end_out  <= frame_end_sum;
  end

  // Each pixel runs its own sum and clamp stages off the shared products
  yuyv_rgb_pixel u_pixel_a (
    .clk  (clk),
    .luma (luma_a),
    .prod (prod),
    .rgb  (rgb_a)
  );

  yuyv_rgb_pixel u_pixel_b (
    .clk  (clk),
    .luma (luma_b),
    .prod (prod),
    .rgb  (rgb_b)
  );

  assign done                 = valid_out;
  assign result.first_red     = rgb_a.red;
  assign result.first_green   = rgb_a.green;
  assign result.first_blue    = rgb_a.blue;
  assign result.second_red    = rgb_b.red;
  assign result.second_green  = rgb_b.green;
  assign result.second_blue   = rgb_b.blue;
  assign result.frame_end_out = frame_end_out;

endmodule

// File: design/yuyv_rgb_pixel.sv
module yuyv_rgb_pixel
  import yuyv_rgb_pkg::*;
(
  input  logic         clk,
  input  logic [7:0]   luma,
  input  chroma_prod_t prod,
  output rgb_t         rgb
);

  sum_t red_sum;
  sum_t green_sum;
  sum_t blue_sum;
  sum_t base;

  assign base = sum_t'({2'b00, luma, 16'd0});

  // Sum stage
  always_ff @(posedge clk) begin
    red_sum   <= base + prod.rv;
    green_sum <= base - prod.gv - prod.gu;
    blue_sum  <= base + prod.bu;
  end

  // Clamp and dim stage
  always_ff @(posedge clk) begin
    rgb.red   <= clamp_dim(red_sum);
    rgb.green <= clamp_dim(green_sum);
    rgb.blue  <= clamp_dim(blue_sum);
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import yuyv_rgb_pkg::*;

  // Colour matrix in fixed point with 16 fractional bits, rounded to nearest
  localparam longint V_TO_RED   = 89831;
  localparam longint V_TO_GREEN = 45744;
  localparam longint U_TO_GREEN = 22127;
  localparam longint U_TO_BLUE  = 113538;
  localparam longint LUMA_SCALE = 65536;
  localparam longint CHROMA_MID = 128;
  localparam int     RANDOM_WORDS = 1050;
  localparam int     MAX_GAP      = 13;
  localparam int     TAIL_CYCLES  = 8;

  // One queued transaction: the word, the idle cycles in front of it, and whether
  // the sender must let the pipeline drain empty before offering it
  typedef struct {
    pixel_word_t word;
    int unsigned gap;
    bit          settle;
  } word_job_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  pixel_word_t pixel_word = '0;
  logic        done;
  result_t     result;

  word_job_t   word_backlog[$];
  result_t     rgb_due[$];
  int          fault_count = 0;
  logic        took = 1'b0;
  int unsigned gap_left = 0;
  bit          gap_armed = 1'b0;

  yuyv_to_rgb24_converter i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .pixel_word (pixel_word),
    .done       (done),
    .result     (result)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Floor the fixed-point sum, clamp it to a byte, then dim by 220/256
  function automatic logic [7:0] channel_level(longint acc);
    longint whole;
    if (acc < 0) return 8'd0;
    whole = acc >>> 16;
    if (whole > 255) whole = 255;
    return 8'((whole * 220) >>> 8);
  endfunction

  function automatic rgb_t pixel_colour(logic [7:0] luma, longint cu, longint cv);
    longint base;
    rgb_t   px;
    base     = longint'(luma) * LUMA_SCALE;
    px.red   = channel_level(base + V_TO_RED * cv);
    px.green = channel_level(base - V_TO_GREEN * cv - U_TO_GREEN * cu);
    px.blue  = channel_level(base + U_TO_BLUE * cu);
    return px;
  endfunction

  // Both pixels of a word share the chroma pair; the frame mark passes through
  function automatic result_t convert_word(pixel_word_t w);
    longint  cu;
    longint  cv;
    rgb_t    px0;
    rgb_t    px1;
    result_t r;
    cu  = longint'(w.blue_chroma) - CHROMA_MID;
    cv  = longint'(w.red_chroma) - CHROMA_MID;
    px0 = pixel_colour(w.first_luma, cu, cv);
    px1 = pixel_colour(w.second_luma, cu, cv);
    r.first_red     = px0.red;
    r.first_green   = px0.green;
    r.first_blue    = px0.blue;
    r.second_red    = px1.red;
    r.second_green  = px1.green;
    r.second_blue   = px1.blue;
    r.frame_end_out = w.frame_end;
    return r;
  endfunction

  task automatic check_channel(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      fault_count++;
      $error("%s: expected %0d, got %0d", field, want, got);
    end
  endtask

  // Sender: hold a transaction until it is taken, then count out the next word's gap.
  // While idle, drive noise on the word so that ignored data is exercised too.
  always @(negedge clk) begin : word_feed
    logic        go;
    pixel_word_t next_word;
    word_job_t   job;
    go        = start && !took;
    next_word = pixel_word;
    if (!go) next_word = {$urandom, 1'($urandom)};
    if (!rst && !go && word_backlog.size() != 0) begin
      if (!gap_armed) begin
        gap_left  = word_backlog[0].gap;
        gap_armed = 1'b1;
      end
      if (gap_left != 0) begin
        gap_left--;
      end else if (!word_backlog[0].settle || rgb_due.size() == 0) begin
        job       = word_backlog.pop_front();
        next_word = job.word;
        go        = 1'b1;
        gap_armed = 1'b0;
      end
    end
    start      <= go;
    pixel_word <= next_word;
  end

  // Sample at the rising edge: predict each accepted transaction, check each result
  always @(posedge clk) begin : result_check
    result_t want;
    took <= !rst && start && !busy;
    if (!rst && start && !busy) rgb_due.push_back(convert_word(pixel_word));
    if (!rst && done !== 1'b0) begin
      if (rgb_due.size() == 0) begin
        fault_count++;
        $error("result strobe with no transaction outstanding");
      end else begin
        want = rgb_due.pop_front();
        check_channel("first_red", want.first_red, result.first_red);
        check_channel("first_green", want.first_green, result.first_green);
        check_channel("first_blue", want.first_blue, result.first_blue);
        check_channel("second_red", want.second_red, result.second_red);
        check_channel("second_green", want.second_green, result.second_green);
        check_channel("second_blue", want.second_blue, result.second_blue);
        check_channel("frame_end_out", 8'(want.frame_end_out), 8'(result.frame_end_out));
      end
    end
  end

  initial begin : run_ctrl
    word_job_t job;
    logic [7:0] chroma_levels[3];
    int guard;
    bit burst;
    chroma_levels = '{8'd0, 8'd128, 8'd255};

    // Directed: black and white luma against chroma levels 0, 128 and 255 on each axis.
    // Low luma with low chroma drives sums negative; high luma with high chroma
    // pushes them past 255 into the clamp.
    for (int u = 0; u < 3; u++) begin
      for (int v = 0; v < 3; v++) begin
        for (int order = 0; order < 2; order++) begin
          job.word.first_luma  = order ? 8'd255 : 8'd0;
          job.word.second_luma = order ? 8'd0 : 8'd255;
          job.word.blue_chroma = chroma_levels[u];
          job.word.red_chroma  = chroma_levels[v];
          job.word.frame_end   = (u == v);
          job.gap              = $urandom_range(0, MAX_GAP);
          job.settle           = 1'b0;
          word_backlog.push_back(job);
        end
      end
    end
    // Video-range luma limits (16, 235) with neutral chroma, then an all-ones word;
    // drain the pipeline before the latter
    job.word   = '{first_luma: 8'd16, blue_chroma: 8'd128, second_luma: 8'd235,
                   red_chroma: 8'd128, frame_end: 1'b0};
    job.gap    = 0;
    job.settle = 1'b0;
    word_backlog.push_back(job);
    job.word   = '1;
    job.gap    = 3;
    job.settle = 1'b1;
    word_backlog.push_back(job);

    // Random: alternate back-to-back bursts with stretches of random gaps,
    // and drain the pipeline now and then
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      burst                = ((i / 40) % 3) == 0;
      job.word.first_luma  = $urandom_range(0, 255);
      job.word.blue_chroma = $urandom_range(0, 255);
      job.word.second_luma = $urandom_range(0, 255);
      job.word.red_chroma  = $urandom_range(0, 255);
      job.word.frame_end   = ($urandom_range(0, 15) == 0);
      job.gap              = burst ? 0 : $urandom_range(0, MAX_GAP);
      job.settle           = (i % 250) == 125;
      word_backlog.push_back(job);
    end

    // Hold reset, then release it on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every transaction to be taken, then for the pipeline to empty
    while (word_backlog.size() != 0 || start) @(posedge clk);
    guard = 0;
    while (rgb_due.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (rgb_due.size() != 0) begin
      fault_count++;
      $error("%0d results never arrived", rgb_due.size());
    end

    if (fault_count == 0) begin
      $display("yuyv_to_rgb24_converter: match");
    end else begin
      $display("yuyv_to_rgb24_converter: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #400000;
    $display("yuyv_to_rgb24_converter: mismatch");
    $finish;
  end

endmodule

// File: sim.f
design/yuyv_rgb_pkg.sv
design/yuyv_rgb_pixel.sv
design/yuyv_to_rgb24_converter.sv
dv/tb.sv
